// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; all use clock and reset of the module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AFC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AFC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Types and constants of the auto-ranging frequency counter.
// ----------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

   localparam int EDGE_WIDTH   = 10;
   localparam int COUNT_WIDTH  = 16;
   localparam int TICK_WIDTH   = 16;
   localparam int FREQ_WIDTH   = 20;
   localparam int THRESH_WIDTH = 20;
   localparam int CSR_DATA_WIDTH  = 20;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int SCALED_WIDTH = COUNT_WIDTH + 4;
   localparam int CMP_WIDTH    = (SCALED_WIDTH > FREQ_WIDTH) ? SCALED_WIDTH : FREQ_WIDTH;
   localparam int SUM_WIDTH    = ((EDGE_WIDTH > COUNT_WIDTH) ? EDGE_WIDTH : COUNT_WIDTH) + 1;

   localparam logic [FREQ_WIDTH-1:0] KHZ_LIMIT = FREQ_WIDTH'(999);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GATE_LOW  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GATE_HIGH = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GATE_TOP  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_HIGH = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TOP  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWER_TH  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_TH  = 3'd6;

   typedef enum logic [1:0] {
      RANGE_LOW  = 2'd0,
      RANGE_HIGH = 2'd1,
      RANGE_TOP  = 2'd2
   } range_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0]   gate_low_ticks;
      logic [TICK_WIDTH-1:0]   gate_high_ticks;
      logic [TICK_WIDTH-1:0]   gate_top_ticks;
      logic [TICK_WIDTH-1:0]   hold_high_ticks;
      logic [TICK_WIDTH-1:0]   hold_top_ticks;
      logic [THRESH_WIDTH-1:0] lower_threshold;
      logic [THRESH_WIDTH-1:0] upper_threshold;
   } cfg_type;

   typedef struct packed {
      logic [FREQ_WIDTH-1:0] frequency_hz;
      logic [1:0]            range_used;
      logic                  show_khz;
      logic                  count_wrapped;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/afc_csr.sv
// ----------------------------------------------------------------------------
// afc_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module afc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [afc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [afc_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   output afc_pkg::cfg_type                          cfg
);
   import afc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GATE_LOW:  cfg_in.gate_low_ticks  = csr_write_data[TICK_WIDTH-1:0];
            CSR_GATE_HIGH: cfg_in.gate_high_ticks = csr_write_data[TICK_WIDTH-1:0];
            CSR_GATE_TOP:  cfg_in.gate_top_ticks  = csr_write_data[TICK_WIDTH-1:0];
            CSR_HOLD_HIGH: cfg_in.hold_high_ticks = csr_write_data[TICK_WIDTH-1:0];
            CSR_HOLD_TOP:  cfg_in.hold_top_ticks  = csr_write_data[TICK_WIDTH-1:0];
            CSR_LOWER_TH:  cfg_in.lower_threshold = csr_write_data[THRESH_WIDTH-1:0];
            CSR_UPPER_TH:  cfg_in.upper_threshold = csr_write_data[THRESH_WIDTH-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_low_ticks  <= TICK_WIDTH'(2000);
         cfg_ff.gate_high_ticks <= TICK_WIDTH'(500);
         cfg_ff.gate_top_ticks  <= TICK_WIDTH'(125);
         cfg_ff.hold_high_ticks <= TICK_WIDTH'(500);
         cfg_ff.hold_top_ticks  <= TICK_WIDTH'(1000);
         cfg_ff.lower_threshold <= THRESH_WIDTH'(10000);
         cfg_ff.upper_threshold <= THRESH_WIDTH'(150000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/afc_gate.sv
// ----------------------------------------------------------------------------
// afc_gate
// Gate, hold and range state; one tick is processed per step strobe.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module afc_gate (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire afc_pkg::cfg_type                cfg,
   input  wire logic                            step,
   input  wire logic [afc_pkg::EDGE_WIDTH-1:0]  edge_count,
   output logic                                 res_valid,
   output afc_pkg::result_type                  res
);
   import afc_pkg::*;

   range_type               range_ff, range_in;
   logic                    holding_ff, holding_in;
   logic [TICK_WIDTH-1:0]   tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0]  total_ff, total_in;
   logic                    wrap_ff, wrap_in;

   logic [TICK_WIDTH-1:0]   tick_inc;
   logic [TICK_WIDTH-1:0]   gate_len;
   logic [TICK_WIDTH-1:0]   hold_len;
   logic [SUM_WIDTH-1:0]    sum;
   logic [COUNT_WIDTH-1:0]  total_new;
   logic                    wrap_new;
   logic [SCALED_WIDTH-1:0] scaled;
   logic [CMP_WIDTH-1:0]    f_cmp, lower_cmp, upper_cmp, max_cmp;
   logic [FREQ_WIDTH-1:0]   freq;
   range_type               range_next;
   logic                    gate_done;

   assign tick_inc  = tick_ff + TICK_WIDTH'(1);
   assign sum       = SUM_WIDTH'(total_ff) + SUM_WIDTH'(edge_count);
   assign total_new = sum[COUNT_WIDTH-1:0];
   assign wrap_new  = wrap_ff | (sum[SUM_WIDTH-1:COUNT_WIDTH] != '0);

   always_comb begin
      case (range_ff)
         RANGE_LOW: begin
            gate_len = cfg.gate_low_ticks;
            hold_len = '0;
            scaled   = SCALED_WIDTH'(total_new);
         end
         RANGE_HIGH: begin
            gate_len = cfg.gate_high_ticks;
            hold_len = cfg.hold_high_ticks;
            scaled   = SCALED_WIDTH'({total_new, 2'b00});
         end
         default: begin
            gate_len = cfg.gate_top_ticks;
            hold_len = cfg.hold_top_ticks;
            scaled   = {total_new, 4'b0000};
         end
      endcase
   end

   assign gate_done = (tick_inc >= gate_len);
   assign f_cmp     = CMP_WIDTH'(scaled);
   assign lower_cmp = CMP_WIDTH'(cfg.lower_threshold);
   assign upper_cmp = CMP_WIDTH'(cfg.upper_threshold);
   assign max_cmp   = CMP_WIDTH'({FREQ_WIDTH{1'b1}});
   assign freq      = (f_cmp > max_cmp) ? {FREQ_WIDTH{1'b1}} : f_cmp[FREQ_WIDTH-1:0];

   always_comb begin
      range_next = range_ff;
      case (range_ff)
         RANGE_LOW: begin
            if (f_cmp >= lower_cmp) range_next = RANGE_HIGH;
         end
         RANGE_HIGH: begin
            if (f_cmp <= lower_cmp) range_next = RANGE_LOW;
            else if (f_cmp >= upper_cmp) range_next = RANGE_TOP;
         end
         default: begin
            range_next = RANGE_TOP;
            if (f_cmp <= lower_cmp) range_next = RANGE_LOW;
            else if (f_cmp <= upper_cmp) range_next = RANGE_HIGH;
         end
      endcase
   end

   // next state
   always_comb begin
      range_in   = range_ff;
      holding_in = holding_ff;
      tick_in    = tick_ff;
      total_in   = total_ff;
      wrap_in    = wrap_ff;
      if (step) begin
         if (holding_ff) begin
            tick_in = tick_inc;
            if (tick_inc >= hold_len) begin
               holding_in = 1'b0;
               tick_in    = '0;
            end
         end else if (!gate_done) begin
            tick_in  = tick_inc;
            total_in = total_new;
            wrap_in  = wrap_new;
         end else begin
            range_in   = range_next;
            tick_in    = '0;
            total_in   = '0;
            wrap_in    = 1'b0;
            holding_in = (range_next == range_ff) && (hold_len != '0);
         end
      end
   end

   // outputs
   always_comb begin
      res_valid         = step && !holding_ff && gate_done && (range_next == range_ff);
      res.frequency_hz  = freq;
      res.range_used    = range_ff;
      res.show_khz      = (freq > KHZ_LIMIT);
      res.count_wrapped = wrap_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff   <= RANGE_LOW;
         holding_ff <= 1'b0;
         tick_ff    <= '0;
         total_ff   <= '0;
         wrap_ff    <= 1'b0;
      end else begin
         range_ff   <= range_in;
         holding_ff <= holding_in;
         tick_ff    <= tick_in;
         total_ff   <= total_in;
         wrap_ff    <= wrap_in;
      end
   end

   `AFC_ASSERT_NXT(a_hold_after_result, res_valid && (hold_len != '0), holding_ff, "no hold after result")
   `AFC_ASSERT_NXT(a_clear_after_result, res_valid, (total_ff == '0) && !wrap_ff && (tick_ff == '0), "gate not cleared")
   `AFC_ASSERT_NXT(a_range_kept, res_valid, $stable(range_ff), "range moved on a result")

endmodule

`default_nettype wire

// File: rtl/core/autorange_frequency_counter.sv
// ----------------------------------------------------------------------------
// autorange_frequency_counter
// Auto-ranging gated frequency counter with three ranges and hold.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transfer per 0.5 ms tick, req_edge_count = edges in that tick.
//   rsp_*  : one transfer per finished gate that did not move the range:
//            frequency in Hz, range, kHz flag and wrap flag.
//   csr_*  : register writes, taken in the cycle of csr_write_enable;
//            write only while no tick is in flight.
//   A tick that ends a gate passes the input register, then the gate logic
//   into the result register, which holds its result for rsp_*.
//   Throughput: one tick per cycle unless a waiting result stalls it, set by
//   the gate update between the input register and the result register.
//   Ticks that end no gate, move the range or fall in the hold give no result.
//   When rsp_ready is low with a result waiting, a tick already in the input
//   register waits there and req_ready drops until the result is taken.
//   Reset: configuration registers return to their default values, range
//   low, counters cleared, both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module autorange_frequency_counter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [afc_pkg::EDGE_WIDTH-1:0]       req_edge_count,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [afc_pkg::FREQ_WIDTH-1:0]            rsp_frequency_hz,
   output logic [1:0]                                rsp_range_used,
   output logic                                      rsp_show_khz,
   output logic                                      rsp_count_wrapped,
   input  wire logic                                 csr_write_enable,
   input  wire logic [afc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [afc_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   import afc_pkg::*;

   cfg_type                cfg;
   logic                   in_valid_ff, in_valid_in;
   logic [EDGE_WIDTH-1:0]  in_edge_ff, in_edge_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;
   logic                   advance;
   logic                   res_valid;
   result_type             res;

   afc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   afc_gate u_gate (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (advance),
      .edge_count (in_edge_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_edge_in  = in_edge_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_edge_in  = req_edge_count;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_edge_ff <= in_edge_in;
      out_ff     <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frequency_hz  = out_ff.frequency_hz;
   assign rsp_range_used    = out_ff.range_used;
   assign rsp_show_khz      = out_ff.show_khz;
   assign rsp_count_wrapped = out_ff.count_wrapped;

   `AFC_ASSERT_IMP(a_stall_only_full, !req_ready, in_valid_ff && out_valid_ff && !rsp_ready, "needless stall")
   `AFC_ASSERT_NXT(a_result_lands, advance && res_valid, out_valid_ff, "result lost")

endmodule

`default_nettype wire

// File: tb/tb_autorange_frequency_counter.sv
// ----------------------------------------------------------------------------
// tb_autorange_frequency_counter
// Self-checking bench for the auto-ranging frequency counter. A table of
// directed ticks walks every range move, hold, zero gate and zero hold case.
// Random phases under several register settings, extremes included, follow.
// Every accepted tick runs through an internal model of the counter. Each
// result transfer is compared field by field with the oldest expected
// reading. Both channels idle at random, and one long result stall
// backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_autorange_frequency_counter;
   import afc_pkg::*;

   localparam int CYCLE_LIMIT    = 600000;
   localparam int SQUEEZE_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 4;
   localparam int EDGE_MAX       = (1 << EDGE_WIDTH) - 1;
   localparam int DIRECTED_ROWS  = 20;

   typedef struct packed {
      logic [EDGE_WIDTH-1:0] edges;
      logic                  typed;
      result_type            want;
   } tick_row_type;

   // low gate 2, high gate 1, top gate 0, high hold 0, top hold 2,
   // thresholds 100 and 1000
   tick_row_type directed_ticks [DIRECTED_ROWS] = '{
      '{10'd0,    1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd0,    1'b1, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd1023, 1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd1023, 1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd50,   1'b1, '{20'd200,  RANGE_HIGH, 1'b0, 1'b0}},
      '{10'd25,   1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd30,   1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd30,   1'b1, '{20'd60,   RANGE_LOW,  1'b0, 1'b0}},
      '{10'd60,   1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd40,   1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd250,  1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd100,  1'b1, '{20'd1600, RANGE_TOP,  1'b1, 1'b0}},
      '{10'd1023, 1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd1023, 1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd62,   1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd1023, 1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd63,   1'b1, '{20'd1008, RANGE_TOP,  1'b1, 1'b0}},
      '{10'd511,  1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd0,    1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}},
      '{10'd6,    1'b0, '{20'd0,    RANGE_LOW,  1'b0, 1'b0}}
   };

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [EDGE_WIDTH-1:0]       req_edge_count = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [FREQ_WIDTH-1:0]       rsp_frequency_hz;
   logic [1:0]                  rsp_range_used;
   logic                        rsp_show_khz;
   logic                        rsp_count_wrapped;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_write_data = '0;

   cfg_type                     meter_cfg;
   range_type                   meter_range;
   bit                          meter_holding;
   logic [TICK_WIDTH-1:0]       meter_ticks;
   logic [COUNT_WIDTH-1:0]      meter_edges;
   bit                          meter_wrapped;

   result_type                  expected_readings [$];
   int                          fault_count = 0;
   int                          cycle_count = 0;
   bit                          steady = 1'b0;
   bit                          squeeze_pending = 1'b0;

   autorange_frequency_counter u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_edge_count    (req_edge_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frequency_hz  (rsp_frequency_hz),
      .rsp_range_used    (rsp_range_used),
      .rsp_show_khz      (rsp_show_khz),
      .rsp_count_wrapped (rsp_count_wrapped),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [TICK_WIDTH-1:0] hold_for(input range_type r);
      case (r)
         RANGE_TOP:  return meter_cfg.hold_top_ticks;
         RANGE_HIGH: return meter_cfg.hold_high_ticks;
         default:    return '0;
      endcase
   endfunction

   // one tick through the counter model; returns 1 when a reading comes out
   function automatic bit predict_tick(input logic [EDGE_WIDTH-1:0] edges,
                                       output result_type reading);
      logic [COUNT_WIDTH:0]  sum;
      logic [TICK_WIDTH-1:0] gate;
      logic [FREQ_WIDTH-1:0] freq;
      range_type             r;
      range_type             next_range;
      reading = '0;
      r = meter_range;
      if (meter_holding) begin
         meter_ticks = meter_ticks + 1'b1;
         if (meter_ticks >= hold_for(r)) begin
            meter_holding = 1'b0;
            meter_ticks = '0;
         end
         return 1'b0;
      end
      sum = meter_edges + edges;
      if (sum[COUNT_WIDTH])
         meter_wrapped = 1'b1;
      meter_edges = sum[COUNT_WIDTH-1:0];
      meter_ticks = meter_ticks + 1'b1;
      case (r)
         RANGE_TOP: begin
            gate = meter_cfg.gate_top_ticks;
            freq = {meter_edges, 4'b0000};
         end
         RANGE_HIGH: begin
            gate = meter_cfg.gate_high_ticks;
            freq = {2'b00, meter_edges, 2'b00};
         end
         default: begin
            gate = meter_cfg.gate_low_ticks;
            freq = {4'b0000, meter_edges};
         end
      endcase
      if (meter_ticks < gate)
         return 1'b0;
      next_range = r;
      case (r)
         RANGE_LOW: begin
            if (freq >= meter_cfg.lower_threshold)
               next_range = RANGE_HIGH;
         end
         RANGE_HIGH: begin
            if (freq <= meter_cfg.lower_threshold)
               next_range = RANGE_LOW;
            else if (freq >= meter_cfg.upper_threshold)
               next_range = RANGE_TOP;
         end
         default: begin
            if (freq <= meter_cfg.lower_threshold)
               next_range = RANGE_LOW;
            else if (freq <= meter_cfg.upper_threshold)
               next_range = RANGE_HIGH;
         end
      endcase
      reading.frequency_hz = freq;
      reading.range_used = r;
      reading.show_khz = (freq > KHZ_LIMIT);
      reading.count_wrapped = meter_wrapped;
      meter_ticks = '0;
      meter_edges = '0;
      meter_wrapped = 1'b0;
      if (next_range != r) begin
         meter_range = next_range;
         return 1'b0;
      end
      meter_holding = (hold_for(r) != '0);
      return 1'b1;
   endfunction

   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic void field_check(input string name, input logic [FREQ_WIDTH-1:0] want,
                                       input logic [FREQ_WIDTH-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         fault_count++;
      end
   endfunction

   function automatic void check_reading();
      result_type want;
      if (expected_readings.size() == 0) begin
         $display("%0t: unexpected reading, frequency_hz %0d range_used %0d",
                  $time, rsp_frequency_hz, rsp_range_used);
         fault_count++;
         return;
      end
      want = expected_readings.pop_front();
      field_check("frequency_hz", want.frequency_hz, rsp_frequency_hz);
      field_check("range_used", FREQ_WIDTH'(want.range_used), FREQ_WIDTH'(rsp_range_used));
      field_check("show_khz", FREQ_WIDTH'(want.show_khz), FREQ_WIDTH'(rsp_show_khz));
      field_check("count_wrapped", FREQ_WIDTH'(want.count_wrapped),
                  FREQ_WIDTH'(rsp_count_wrapped));
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_GATE_LOW:  meter_cfg.gate_low_ticks  = data[TICK_WIDTH-1:0];
         CSR_GATE_HIGH: meter_cfg.gate_high_ticks = data[TICK_WIDTH-1:0];
         CSR_GATE_TOP:  meter_cfg.gate_top_ticks  = data[TICK_WIDTH-1:0];
         CSR_HOLD_HIGH: meter_cfg.hold_high_ticks = data[TICK_WIDTH-1:0];
         CSR_HOLD_TOP:  meter_cfg.hold_top_ticks  = data[TICK_WIDTH-1:0];
         CSR_LOWER_TH:  meter_cfg.lower_threshold = data[THRESH_WIDTH-1:0];
         CSR_UPPER_TH:  meter_cfg.upper_threshold = data[THRESH_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input int unsigned gate_low, input int unsigned gate_high,
                                input int unsigned gate_top, input int unsigned hold_high,
                                input int unsigned hold_top, input int unsigned lower_th,
                                input int unsigned upper_th);
      write_reg(CSR_GATE_LOW, CSR_DATA_WIDTH'(gate_low));
      write_reg(CSR_GATE_HIGH, CSR_DATA_WIDTH'(gate_high));
      write_reg(CSR_GATE_TOP, CSR_DATA_WIDTH'(gate_top));
      write_reg(CSR_HOLD_HIGH, CSR_DATA_WIDTH'(hold_high));
      write_reg(CSR_HOLD_TOP, CSR_DATA_WIDTH'(hold_top));
      write_reg(CSR_LOWER_TH, CSR_DATA_WIDTH'(lower_th));
      write_reg(CSR_UPPER_TH, CSR_DATA_WIDTH'(upper_th));
      csr_write_enable <= 1'b0;
   endtask

   // stop offering ticks and let every pending reading drain
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_tick(input logic [EDGE_WIDTH-1:0] edges, input bit typed,
                            input result_type want);
      result_type  reading;
      int unsigned gap;
      bit          makes;
      gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_edge_count <= edges;
      do
         @(posedge clock);
      while (!req_ready);
      makes = predict_tick(edges, reading);
      if (typed)
         expected_readings.push_back(want);
      else if (makes)
         expected_readings.push_back(reading);
   endtask

   // bursts around a target edge rate, with some noise and extremes mixed in
   task automatic run_phase(input int unsigned items, input bit hot, input bit calm);
      int unsigned           left_in_burst;
      int unsigned           target;
      int unsigned           pick;
      int                    jit;
      logic [EDGE_WIDTH-1:0] edges;
      left_in_burst = 0;
      target = 0;
      steady = calm || ($urandom_range(0, 3) == 0);
      repeat (items) begin
         if (left_in_burst == 0) begin
            left_in_burst = $urandom_range(4, 30);
            pick = $urandom_range(0, 9);
            if (hot)
               target = $urandom_range(900, EDGE_MAX);
            else if (pick < 2)
               target = $urandom_range(990, 1010);
            else if (pick < 4)
               target = $urandom_range(0, 40);
            else
               target = $urandom_range(0, EDGE_MAX);
         end
         left_in_burst--;
         pick = $urandom_range(0, 99);
         if (pick < 70 || (hot && pick < 95)) begin
            jit = int'(target) + int'($urandom_range(0, 16)) - 8;
            if (jit < 0)
               jit = 0;
            if (jit > EDGE_MAX)
               jit = EDGE_MAX;
            edges = jit[EDGE_WIDTH-1:0];
         end else if (pick < 85) begin
            edges = EDGE_WIDTH'($urandom_range(0, EDGE_MAX));
         end else if (pick < 93) begin
            edges = '0;
         end else begin
            edges = '1;
         end
         send_tick(edges, 1'b0, '0);
      end
   endtask

   // result side: random stalls plus one long hold-off on request
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            check_reading();
         if (stall_left == 0 && squeeze_pending) begin
            squeeze_pending = 1'b0;
            stall_left = SQUEEZE_CYCLES;
         end else if (stall_left == 0 && $urandom_range(0, 2) == 0) begin
            stall_left = idle_len();
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned lower_th;
      meter_cfg.gate_low_ticks  = 16'd2000;
      meter_cfg.gate_high_ticks = 16'd500;
      meter_cfg.gate_top_ticks  = 16'd125;
      meter_cfg.hold_high_ticks = 16'd500;
      meter_cfg.hold_top_ticks  = 16'd1000;
      meter_cfg.lower_threshold = 20'd10000;
      meter_cfg.upper_threshold = 20'd150000;
      meter_range = RANGE_LOW;
      meter_holding = 1'b0;
      meter_ticks = '0;
      meter_edges = '0;
      meter_wrapped = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      load_settings(2, 1, 0, 0, 2, 100, 1000);
      foreach (directed_ticks[i])
         send_tick(directed_ticks[i].edges, directed_ticks[i].typed, directed_ticks[i].want);
      settle();

      // thresholds at maximum pin the low range; long gate lets the count wrap
      load_settings(90, 65535, 65535, 65535, 65535, 1048575, 1048575);
      run_phase(190, 1'b1, 1'b0);
      settle();

      load_settings(3, 2, 1, 3, 5, 500, 5000);
      run_phase(120, 1'b0, 1'b1);
      settle();

      // all zero: single-tick gates, no hold, range climbs to top, zero drops to low
      load_settings(0, 0, 0, 0, 0, 0, 0);
      squeeze_pending = 1'b1;
      run_phase(130, 1'b0, 1'b0);
      settle();

      load_settings(1, 4, 2, 2, 4, 1010, 3000);
      run_phase(110, 1'b0, 1'b0);
      settle();

      repeat (2) begin
         lower_th = $urandom_range(0, 4000);
         load_settings($urandom_range(0, 8), $urandom_range(1, 6), $urandom_range(0, 4),
                       $urandom_range(0, 6), $urandom_range(0, 6), lower_th,
                       lower_th + $urandom_range(0, 40000));
         run_phase(65, 1'b0, 1'b0);
         settle();
      end

      if (fault_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
